// ===== rtl/core/midi_file_to_sequencer_commands_defines.svh =====
// Assertion macros for the MIDI file parser.
// Included by the files that carry concurrent assertions.
`ifndef MIDI_FILE_TO_SEQUENCER_COMMANDS_DEFINES_SVH
`define MIDI_FILE_TO_SEQUENCER_COMMANDS_DEFINES_SVH
`ifndef SYNTHESIS
`define MSC_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");
`define MSC_ASSERT_RST(label, clk, prop) \
	label: assert property (@(posedge clk) prop) else $error("%m failed");
`else
`define MSC_ASSERT(label, clk, rst_n, prop)
`define MSC_ASSERT_RST(label, clk, prop)
`endif
`endif

// ===== rtl/core/msc_pkg.sv =====
// Shared types and constants of the MIDI file parser.
// No dependencies.
`default_nettype none
package msc_pkg;
	localparam int MAX_TRACKS_DEF      = 16;
	localparam int TRACK_BYTES_MAX_DEF = 65536;

	typedef enum logic [2:0] {
		KIND_HEADER = 3'd0,
		KIND_CMD    = 3'd1,
		KIND_TRACK  = 3'd2,
		KIND_FILE   = 3'd3,
		KIND_ERROR  = 3'd4
	} kind_t;

	typedef enum logic [3:0] {
		ERR_NONE     = 4'd0,
		ERR_MTHD     = 4'd1,
		ERR_HSIZE    = 4'd2,
		ERR_FORMAT   = 4'd3,
		ERR_TRACKS   = 4'd4,
		ERR_SMPTE    = 4'd5,
		ERR_MTRK     = 4'd6,
		ERR_EOT_LEN  = 4'd7,
		ERR_STATUS   = 4'd8,
		ERR_SHORT    = 4'd9,
		ERR_OVERFLOW = 4'd10
	} err_t;

	typedef enum logic [4:0] {
		PH_HDR_ID    = 5'd0,
		PH_HDR_SIZE  = 5'd1,
		PH_HDR_FMT   = 5'd2,
		PH_HDR_NTRK  = 5'd3,
		PH_HDR_DIV   = 5'd4,
		PH_TRK_ID    = 5'd5,
		PH_TRK_SIZE  = 5'd6,
		PH_DELTA     = 5'd7,
		PH_STATUS    = 5'd8,
		PH_DATA1     = 5'd9,
		PH_DATA2     = 5'd10,
		PH_META_TYPE = 5'd11,
		PH_META_LEN  = 5'd12,
		PH_SYSEX_LEN = 5'd13,
		PH_SKIP      = 5'd14,
		PH_DONE      = 5'd15,
		PH_ERROR     = 5'd16
	} phase_t;

	typedef struct packed {
		logic [3:0]  kind;
		logic [7:0]  opcode;
		logic [7:0]  operand_first;
		logic [7:0]  operand_second;
		logic [12:0] repeat_count;
		logic [3:0]  error_code;
		logic        last;
		logic [3:0]  track_number;
		logic [16:0] track_byte_count;
		logic        file_format;
		logic [4:0]  track_total;
		logic [14:0] ticks_per_quarter;
	} res_t;

	localparam logic [7:0] OP_DELAY8   = 8'h10;
	localparam logic [7:0] OP_DELAY16  = 8'h20;
	localparam logic [7:0] OP_NOTE_ON  = 8'h40;
	localparam logic [7:0] OP_NOTE_OFF = 8'h50;
	localparam logic [7:0] OP_OTHER    = 8'h60;
	localparam logic [7:0] OP_TOUCH    = 8'h70;
	localparam logic [7:0] OP_CTRL     = 8'h90;
	localparam logic [7:0] OP_CTRL4    = 8'hA0;
	localparam logic [7:0] OP_PROGRAM  = 8'hD0;

	function automatic logic [1:0] data_count(input logic [7:0] st);
		case (st[7:4])
			4'h8, 4'h9, 4'hA, 4'hB, 4'hE: data_count = 2'd2;
			4'hC, 4'hD:                   data_count = 2'd1;
			default:                      data_count = 2'd0;
		endcase
	endfunction
endpackage
`default_nettype wire

// ===== rtl/core/midi_file_to_sequencer_commands.sv =====
// Top level of the MIDI file parser: byte stream in, sequencer results out.
// Depends on msc_pkg and midi_file_to_sequencer_commands_defines.svh.
//
// Usage: s_axis carries one item per transfer: s_axis_tuser is req_type (1 marks
// end of input), s_axis_tdata the file byte. m_axis gives the results, with the
// result kind on m_axis_tuser and the other fields on m_axis_tdata; a byte may
// cause up to two (header plus file done, track done plus file done, or a run
// of full delays plus the remainder delay); m_axis_tlast marks the final result
// of a byte. A byte with no result leaves nothing behind.
// Flow: the results of a byte are written into the two-entry result buffer
// at the edge that takes the byte, so the first is valid in the next cycle; a
// second result follows once the first is taken. Throughput is one byte per
// cycle while each byte gives at most one result and the receiver is ready; a
// byte that gives two holds input until the first is taken. The parse state is
// updated in the cycle the byte is taken; the result buffer sets the pace.
// When the receiver stalls, results queue in the buffer and s_axis_tready
// falls once it cannot hold a new byte's worst case. Reset (arst_n low)
// returns to the header id phase and empties the buffer. Errors are sticky:
// after one error result the block swallows all input until reset, as it
// does after file done.
`default_nettype none
`include "midi_file_to_sequencer_commands_defines.svh"
module midi_file_to_sequencer_commands #(
	parameter int MAX_TRACKS      = msc_pkg::MAX_TRACKS_DEF,
	parameter int TRACK_BYTES_MAX = msc_pkg::TRACK_BYTES_MAX_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,  // data_byte
	input  wire logic        s_axis_tuser,  // req_type
	input  wire logic        m_axis_tready,
	output logic             m_axis_tvalid,
	output logic [87:0]      m_axis_tdata,
	// opcode, operand_first, operand_second, repeat_count, error_code,
	// track_number, track_byte_count, file_format, track_total,
	// ticks_per_quarter, zero fill
	output logic [2:0]       m_axis_tuser,  // result_kind
	output logic             m_axis_tlast   // last
);
	localparam logic [16:0] TBMAX = 17'(TRACK_BYTES_MAX);
	localparam logic [4:0]  MAXT  = 5'(MAX_TRACKS);

	msc_pkg::phase_t phase_q;
	logic [2:0]  fbi_q;
	logic [31:0] fasm_q;
	logic [27:0] vl_q;
	logic [7:0]  rs_q, held_q, meta_q;
	logic [27:0] skip_q;
	logic [4:0]  ntrk_q, trk_q;
	logic [16:0] used_q;
	logic        fmt_q;

	msc_pkg::res_t buf_q [2];
	logic [1:0] cnt_q;

	// next-state signals
	msc_pkg::phase_t ph_n;
	logic [2:0]  fbi_n;
	logic [31:0] fasm_n;
	logic [27:0] vl_n;
	logic [7:0]  rs_n, held_n, meta_n;
	logic [27:0] skip_n;
	logic [4:0]  ntrk_n, trk_n;
	logic [16:0] used_n;
	logic        fmt_n;
	msc_pkg::res_t r0, r1;
	logic [1:0]  nres;

	logic in_fire, out_fire;
	logic [7:0] b;
	logic [31:0] fa_shift;
	logic [2:0] fbi_inc;
	logic fixed_done;
	logic [27:0] vl_base;
	logic [27:0] vl_acc;
	logic vl_done;
	// delay split
	logic [12:0] dn;
	logic [15:0] drem;
	logic [16:0] dbytes;
	// channel
	logic [7:0] ch_st, ch_d0, ch_d1, ch_op, ch_a, ch_b;
	logic [16:0] ch_bytes;
	logic [17:0] used_sum;

	assign in_fire  = s_axis_tvalid && s_axis_tready;
	assign out_fire = m_axis_tvalid && m_axis_tready;
	assign b        = s_axis_tdata;
	assign s_axis_tready = (cnt_q == 2'd0) || (cnt_q == 2'd1 && m_axis_tready);

	assign fa_shift = {fasm_q[23:0], b};
	assign fbi_inc  = fbi_q + 3'd1;
	assign fixed_done = (phase_q >= msc_pkg::PH_HDR_FMT && phase_q <= msc_pkg::PH_HDR_DIV)
		? (fbi_inc >= 3'd2) : (fbi_inc >= 3'd4);
	assign vl_base = (fbi_q == 3'd0) ? 28'd0 : vl_q;
	assign vl_acc  = {vl_base[20:0], b[6:0]};
	assign vl_done = !b[7] || (fbi_inc >= 3'd4);

	// n = (d-1)/65535 via d-1 = q*65536 + r: n = q + carry, rem = q + r + 1 - carry*65535
	logic [27:0] dm1;
	logic [12:0] q0;
	logic [16:0] r0s;
	logic        dcarry;
	always_comb begin
		dm1    = vl_acc - 28'd1;
		q0     = {1'b0, dm1[27:16]};
		r0s    = {1'b0, dm1[15:0]} + {4'd0, q0};
		dcarry = (r0s >= 17'd65535);
		dn     = dcarry ? q0 + 13'd1 : q0;
		drem   = 16'(r0s + 17'd1 - (dcarry ? 17'd65535 : 17'd0));
		dbytes = {3'd0, dn, 1'b0} + {4'd0, dn} + ((drem <= 16'd255) ? 17'd2 : 17'd3);
	end

	always_comb begin
		ch_st = rs_q;
		ch_d0 = (phase_q == msc_pkg::PH_DATA2) ? held_q : b;
		ch_d1 = b;
		ch_b  = 8'd0;
		ch_bytes = 17'd2;
		case (ch_st[7:4])
			4'h8: begin ch_op = msc_pkg::OP_NOTE_OFF; ch_a = ch_d0; end
			4'h9: begin
				ch_op = msc_pkg::OP_NOTE_ON; ch_a = ch_d0; ch_b = ch_d1; ch_bytes = 17'd3;
			end
			4'hA: begin ch_op = msc_pkg::OP_TOUCH; ch_a = ch_d1; end
			4'hB: begin
				ch_op = (ch_d0 == 8'd4) ? msc_pkg::OP_CTRL4 : msc_pkg::OP_CTRL; ch_a = ch_d1;
			end
			4'hC: begin ch_op = msc_pkg::OP_PROGRAM; ch_a = ch_d0; end
			4'hD: begin ch_op = msc_pkg::OP_TOUCH; ch_a = ch_d0; end
			default: begin ch_op = msc_pkg::OP_OTHER; ch_a = ch_d1; end
		endcase
	end

	always_comb begin
		logic [1:0]  dc;
		logic        do_ch;
		dc   = 2'd0;
		do_ch = 1'b0;
		ph_n = phase_q; fbi_n = fbi_q; fasm_n = fasm_q; vl_n = vl_q;
		rs_n = rs_q; held_n = held_q; meta_n = meta_q; skip_n = skip_q;
		ntrk_n = ntrk_q; trk_n = trk_q; used_n = used_q; fmt_n = fmt_q;
		r0 = '0; r1 = '0; nres = 2'd0;
		r0.track_number = trk_q[3:0];
		r1.track_number = 4'd0;
		used_sum = 18'd0;
		if (phase_q >= msc_pkg::PH_DONE) begin
			nres = 2'd0;
		end else if (s_axis_tuser) begin
			r0.kind = 4'(msc_pkg::KIND_ERROR);
			r0.error_code = msc_pkg::ERR_SHORT;
			nres = 2'd1; ph_n = msc_pkg::PH_ERROR;
		end else if (phase_q <= msc_pkg::PH_TRK_SIZE) begin
			fasm_n = fa_shift; fbi_n = fbi_inc;
			if (fixed_done) begin
				fbi_n = 3'd0; fasm_n = 32'd0;
				r0.kind = 4'(msc_pkg::KIND_ERROR);
				case (phase_q)
					msc_pkg::PH_HDR_ID: begin
						if (fa_shift != 32'h4D546864) begin
							r0.error_code = msc_pkg::ERR_MTHD; nres = 2'd1;
						end else ph_n = msc_pkg::PH_HDR_SIZE;
					end
					msc_pkg::PH_HDR_SIZE: begin
						if (fa_shift != 32'd6) begin
							r0.error_code = msc_pkg::ERR_HSIZE; nres = 2'd1;
						end else ph_n = msc_pkg::PH_HDR_FMT;
					end
					msc_pkg::PH_HDR_FMT: begin
						if (fa_shift[15:0] > 16'd1) begin
							r0.error_code = msc_pkg::ERR_FORMAT; nres = 2'd1;
						end else begin fmt_n = fa_shift[0]; ph_n = msc_pkg::PH_HDR_NTRK; end
					end
					msc_pkg::PH_HDR_NTRK: begin
						if (fa_shift[15:0] > 16'(MAXT)) begin
							r0.error_code = msc_pkg::ERR_TRACKS; nres = 2'd1;
						end else begin ntrk_n = fa_shift[4:0]; ph_n = msc_pkg::PH_HDR_DIV; end
					end
					msc_pkg::PH_HDR_DIV: begin
						if (fa_shift[15]) begin
							r0.error_code = msc_pkg::ERR_SMPTE; nres = 2'd1;
						end else begin
							r0 = '0;
							r0.kind = 4'(msc_pkg::KIND_HEADER);
							r0.file_format = fmt_q;
							r0.track_total = ntrk_q;
							r0.ticks_per_quarter = fa_shift[14:0];
							trk_n = 5'd0;
							if (ntrk_q == 5'd0) begin
								r1.kind = 4'(msc_pkg::KIND_FILE);
								nres = 2'd2; ph_n = msc_pkg::PH_DONE;
							end else begin
								nres = 2'd1; ph_n = msc_pkg::PH_TRK_ID;
							end
						end
					end
					msc_pkg::PH_TRK_ID: begin
						if (fa_shift != 32'h4D54726B) begin
							r0.error_code = msc_pkg::ERR_MTRK; nres = 2'd1;
						end else ph_n = msc_pkg::PH_TRK_SIZE;
					end
					default: begin
						rs_n = 8'd0; used_n = 17'd0; ph_n = msc_pkg::PH_DELTA;
					end
				endcase
				if (nres != 2'd0 && r0.kind == 4'(msc_pkg::KIND_ERROR))
					ph_n = msc_pkg::PH_ERROR;
			end
		end else begin
			case (phase_q)
				msc_pkg::PH_DELTA: begin
					vl_n = vl_acc; fbi_n = fbi_inc;
					if (vl_done) begin
						fbi_n = 3'd0; ph_n = msc_pkg::PH_STATUS;
						if (vl_acc != 28'd0) begin
							used_sum = {1'b0, used_q} + {1'b0, dbytes};
							if (used_sum > {1'b0, TBMAX}) begin
								r0.kind = 4'(msc_pkg::KIND_ERROR);
								r0.error_code = msc_pkg::ERR_OVERFLOW;
								nres = 2'd1; ph_n = msc_pkg::PH_ERROR;
							end else begin
								used_n = used_sum[16:0];
								r1 = r0;
								r1.kind = 4'(msc_pkg::KIND_CMD);
								r1.repeat_count = 13'd1;
								if (drem <= 16'd255) begin
									r1.opcode = msc_pkg::OP_DELAY8;
									r1.operand_first = drem[7:0];
								end else begin
									r1.opcode = msc_pkg::OP_DELAY16;
									r1.operand_first = drem[7:0];
									r1.operand_second = drem[15:8];
								end
								if (dn != 13'd0) begin
									r0.kind = 4'(msc_pkg::KIND_CMD);
									r0.opcode = msc_pkg::OP_DELAY16;
									r0.operand_first = 8'hFF;
									r0.operand_second = 8'hFF;
									r0.repeat_count = dn;
									nres = 2'd2;
								end else begin
									r0 = r1; nres = 2'd1;
								end
							end
						end
					end
				end
				msc_pkg::PH_STATUS: begin
					if (b[7]) begin
						if (b == 8'hFF) ph_n = msc_pkg::PH_META_TYPE;
						else if (b == 8'hF0 || b == 8'hF7) ph_n = msc_pkg::PH_SYSEX_LEN;
						else if (msc_pkg::data_count(b) == 2'd0) begin
							r0.kind = 4'(msc_pkg::KIND_ERROR);
							r0.error_code = msc_pkg::ERR_STATUS;
							nres = 2'd1; ph_n = msc_pkg::PH_ERROR;
						end else begin
							rs_n = b; ph_n = msc_pkg::PH_DATA1;
						end
					end else begin
						dc = msc_pkg::data_count(rs_q);
						if (dc == 2'd0) begin
							r0.kind = 4'(msc_pkg::KIND_ERROR);
							r0.error_code = msc_pkg::ERR_STATUS;
							nres = 2'd1; ph_n = msc_pkg::PH_ERROR;
						end else if (dc == 2'd1) do_ch = 1'b1;
						else begin held_n = b; ph_n = msc_pkg::PH_DATA2; end
					end
				end
				msc_pkg::PH_DATA1: begin
					if (msc_pkg::data_count(rs_q) == 2'd1) do_ch = 1'b1;
					else begin held_n = b; ph_n = msc_pkg::PH_DATA2; end
				end
				msc_pkg::PH_DATA2: do_ch = 1'b1;
				msc_pkg::PH_META_TYPE: begin
					meta_n = b; fbi_n = 3'd0; ph_n = msc_pkg::PH_META_LEN;
				end
				msc_pkg::PH_META_LEN, msc_pkg::PH_SYSEX_LEN: begin
					vl_n = vl_acc; fbi_n = fbi_inc;
					if (vl_done) begin
						fbi_n = 3'd0;
						if (phase_q == msc_pkg::PH_META_LEN && meta_q == 8'h2F) begin
							if (vl_acc != 28'd0) begin
								r0.kind = 4'(msc_pkg::KIND_ERROR);
								r0.error_code = msc_pkg::ERR_EOT_LEN;
								nres = 2'd1; ph_n = msc_pkg::PH_ERROR;
							end else begin
								r0.kind = 4'(msc_pkg::KIND_TRACK);
								r0.track_byte_count = used_q;
								trk_n = trk_q + 5'd1;
								if (trk_n >= ntrk_q) begin
									r1.kind = 4'(msc_pkg::KIND_FILE);
									nres = 2'd2; ph_n = msc_pkg::PH_DONE;
								end else begin
									nres = 2'd1; ph_n = msc_pkg::PH_TRK_ID;
								end
							end
						end else begin
							rs_n = 8'd0; skip_n = vl_acc;
							ph_n = (vl_acc == 28'd0) ? msc_pkg::PH_DELTA : msc_pkg::PH_SKIP;
						end
					end
				end
				msc_pkg::PH_SKIP: begin
					skip_n = skip_q - 28'd1;
					if (skip_n == 28'd0) ph_n = msc_pkg::PH_DELTA;
				end
				default: ;
			endcase
			if (do_ch) begin
				used_sum = {1'b0, used_q} + {1'b0, ch_bytes};
				if (used_sum > {1'b0, TBMAX}) begin
					r0.kind = 4'(msc_pkg::KIND_ERROR);
					r0.error_code = msc_pkg::ERR_OVERFLOW;
					nres = 2'd1; ph_n = msc_pkg::PH_ERROR;
				end else begin
					used_n = used_sum[16:0];
					ph_n = msc_pkg::PH_DELTA;
					r0.kind = 4'(msc_pkg::KIND_CMD);
					r0.opcode = ch_op; r0.operand_first = ch_a; r0.operand_second = ch_b;
					r0.repeat_count = 13'd1;
					nres = 2'd1;
				end
			end
		end
		if (nres == 2'd1) r0.last = 1'b1;
		if (nres == 2'd2) r1.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= msc_pkg::PH_HDR_ID;
			fbi_q <= '0; fasm_q <= '0; vl_q <= '0; rs_q <= '0; held_q <= '0;
			meta_q <= '0; skip_q <= '0; ntrk_q <= '0; trk_q <= '0; used_q <= '0;
			fmt_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (in_fire) begin
				phase_q <= ph_n; fbi_q <= fbi_n; fasm_q <= fasm_n; vl_q <= vl_n;
				rs_q <= rs_n; held_q <= held_n; meta_q <= meta_n; skip_q <= skip_n;
				ntrk_q <= ntrk_n; trk_q <= trk_n; used_q <= used_n; fmt_q <= fmt_n;
			end
			cnt_q <= cnt_q - {1'b0, out_fire} + (in_fire ? nres : 2'd0);
		end
	end

	// result buffer: entry 0 is the head
	always_ff @(posedge clk) begin
		logic [1:0] base;
		logic       wr;
		base = cnt_q - {1'b0, out_fire};
		wr   = in_fire && (nres != 2'd0);
		if (wr && base == 2'd0) begin
			buf_q[0] <= r0;
			buf_q[1] <= r1;
		end else begin
			if (out_fire) buf_q[0] <= buf_q[1];
			if (wr) buf_q[1] <= r0;
		end
	end

	assign m_axis_tvalid = (cnt_q != 2'd0);
	assign m_axis_tlast  = buf_q[0].last;
	assign m_axis_tuser  = buf_q[0].kind[2:0];
	assign m_axis_tdata  = {
		5'd0,
		buf_q[0].ticks_per_quarter,
		buf_q[0].track_total,
		buf_q[0].file_format,
		buf_q[0].track_byte_count,
		buf_q[0].track_number,
		buf_q[0].error_code,
		buf_q[0].repeat_count,
		buf_q[0].operand_second,
		buf_q[0].operand_first,
		buf_q[0].opcode
	};

	`MSC_ASSERT(a_cnt_range, clk, arst_n, cnt_q != 2'd3)
	`MSC_ASSERT(a_no_in_when_full, clk, arst_n, (cnt_q == 2'd2) |-> !s_axis_tready)
	`MSC_ASSERT(a_err_sticky, clk, arst_n,
		(phase_q == msc_pkg::PH_ERROR) |=> (phase_q == msc_pkg::PH_ERROR))
	`MSC_ASSERT(a_done_quiet, clk, arst_n,
		(phase_q >= msc_pkg::PH_DONE && in_fire) |=> (cnt_q <= $past(cnt_q)))
endmodule
`default_nettype wire
